// ===== hw/rtl/rpd_pkg.sv =====
// shared constants and codes for the random permutation drawer
package rpd_pkg;

	// table depth and derived widths
	localparam int MAX_COUNT = 256;
	localparam int OFS_W = $clog2(MAX_COUNT);
	localparam int CNT_W = $clog2(MAX_COUNT + 1);

	// fixed field widths
	localparam int VAL_W = 32;
	localparam int RW_W = 32;
	localparam int CFG_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_CNT_W = 9;
	localparam int STAT_W = 2;
	localparam int CMP_W = (CNT_W > CFG_CNT_W) ? CNT_W : CFG_CNT_W;
	localparam int DIV_CNT_W = $clog2(RW_W);

	// input item kinds
	localparam logic KIND_RESTART = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_DRAWN = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RESTART = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_COUNT = 1'd1;

endpackage

// ===== hw/rtl/rpd_ram.sv =====
// generic simple dual-port ram with registered read
module rpd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/rpd_mod.sv =====
// bit-serial modulo unit: one restoring step per cycle
module rpd_mod (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [rpd_pkg::RW_W-1:0] dividend,
	input  logic [rpd_pkg::CNT_W-1:0] divisor,
	output logic                     done,
	output logic [rpd_pkg::CNT_W-1:0] remainder
);

	import rpd_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [RW_W-1:0]      dvd_q;
	logic [CNT_W-1:0]     div_q;
	logic [CNT_W-1:0]     rem_q;
	logic [CNT_W:0]       trial;
	logic [CNT_W-1:0]     rem_next;

	// shift in the next dividend bit and subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[RW_W-1]};
		if (trial >= {1'b0, div_q}) begin
			rem_next = CNT_W'(trial - {1'b0, div_q});
		end else begin
			rem_next = CNT_W'(trial);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == DIV_CNT_W'(RW_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(RW_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RW_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/random_permutation_drawer_unit.sv =====
// Random permutation drawer. A restart transaction (kind 0) refills the offset table
// with 0..n-1, n being range_count saturated to 256. A draw transaction (kind 1)
// reduces random_word modulo the remaining count in a bit-serial unit, reads the
// chosen offset, then compacts the table by moving every later entry down one place
// through the single-port-each-way table ram, one entry per cycle. A draw with an
// empty table answers with the empty status. The block takes one transaction at a
// time; the result sits in an output register so a new transaction can start while it
// waits. Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, since the block itself does not enforce this.
module random_permutation_drawer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [rpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rpd_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        kind,
	input  logic [rpd_pkg::RW_W-1:0]    random_word,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [rpd_pkg::VAL_W-1:0]   drawn_value,
	output logic                        final_draw,
	output logic [rpd_pkg::STAT_W-1:0]  status
);

	import rpd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FILL = 3'd1;
	localparam logic [2:0] ST_DIV = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_GET = 3'd4;
	localparam logic [2:0] ST_SHIFT = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0]           state_q;
	logic [VAL_W-1:0]     range_min_q;
	logic [CFG_CNT_W-1:0] range_count_q;
	logic [CNT_W-1:0]     remaining_q;
	logic [CNT_W-1:0]     ptr_q;
	logic [OFS_W-1:0]     wa_q;
	logic                 pend_q;
	logic [VAL_W-1:0]     res_value_q;
	logic                 res_final_q;
	logic [STAT_W-1:0]    res_status_q;
	logic                 result_valid_q;
	logic [VAL_W-1:0]     drawn_value_q;
	logic                 final_draw_q;
	logic [STAT_W-1:0]    status_q;

	logic                 accept;
	logic                 out_free;
	logic [CNT_W-1:0]     fill_n;
	logic                 div_start;
	logic                 div_done;
	logic [CNT_W-1:0]     div_rem;
	logic                 ram_we;
	logic [OFS_W-1:0]     ram_wa;
	logic [OFS_W-1:0]     ram_wd;
	logic [OFS_W-1:0]     ram_ra;
	logic [OFS_W-1:0]     ram_rd;
	logic                 ptr_live;

	assign item_stall = (state_q != ST_IDLE);
	assign accept = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;
	assign div_start = accept && (kind == KIND_DRAW) && (remaining_q != '0);
	assign ptr_live = (ptr_q < remaining_q);

	always_comb begin
		if (CMP_W'(range_count_q) > CMP_W'(MAX_COUNT)) begin
			fill_n = CNT_W'(MAX_COUNT);
		end else begin
			fill_n = CNT_W'(range_count_q);
		end
	end

	// table ram port steering
	always_comb begin
		ram_we = 1'b0;
		ram_wa = ptr_q[OFS_W-1:0];
		ram_wd = ptr_q[OFS_W-1:0];
		ram_ra = ptr_q[OFS_W-1:0];
		unique case (state_q)
			ST_FILL: begin
				ram_we = ptr_live;
			end
			ST_READ: begin
				ram_ra = div_rem[OFS_W-1:0];
			end
			ST_SHIFT: begin
				ram_we = pend_q;
				ram_wa = wa_q;
				ram_wd = ram_rd;
			end
			default: begin
			end
		endcase
	end

	rpd_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (random_word),
		.divisor   (remaining_q),
		.done      (div_done),
		.remainder (div_rem)
	);

	rpd_ram #(
		.WIDTH (OFS_W),
		.DEPTH (MAX_COUNT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_wa),
		.wdata (ram_wd),
		.raddr (ram_ra),
		.rdata (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			range_min_q <= '0;
			range_count_q <= CFG_CNT_W'(MAX_COUNT);
			remaining_q <= '0;
			pend_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_RANGE_MIN: range_min_q <= cfg_data;
					REG_RANGE_COUNT: range_count_q <= cfg_data[CFG_CNT_W-1:0];
					default: begin
					end
				endcase
			end

			// output register reloads in the same cycle it is taken
			if ((state_q == ST_DONE) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_RESTART) begin
							remaining_q <= fill_n;
							state_q <= ST_FILL;
						end else if (remaining_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_FILL: begin
					if (!ptr_live) begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_GET;
				end
				ST_GET: begin
					pend_q <= 1'b0;
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					pend_q <= ptr_live;
					if (!ptr_live && !pend_q) begin
						remaining_q <= remaining_q - CNT_W'(1);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ptr_q <= '0;
				res_value_q <= '0;
				res_final_q <= 1'b0;
				res_status_q <= (kind == KIND_RESTART) ? STAT_RESTART : STAT_EMPTY;
			end
			ST_FILL: begin
				if (ptr_live) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
			end
			ST_READ: begin
				ptr_q <= div_rem + CNT_W'(1);
			end
			ST_GET: begin
				res_value_q <= range_min_q + VAL_W'(ram_rd);
			end
			ST_SHIFT: begin
				// read entry ptr while writing the one fetched last cycle one place lower
				if (ptr_live) begin
					ptr_q <= ptr_q + CNT_W'(1);
					wa_q <= ptr_q[OFS_W-1:0] - OFS_W'(1);
				end
				res_final_q <= (remaining_q == CNT_W'(1));
				res_status_q <= STAT_DRAWN;
			end
			ST_DONE: begin
				if (out_free) begin
					drawn_value_q <= res_value_q;
					final_draw_q <= res_final_q;
					status_q <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign drawn_value = drawn_value_q;
	assign final_draw = final_draw_q;
	assign status = status_q;

`ifndef SYNTHESIS
	a_remaining_bound: assert property (@(posedge clk) disable iff (!arst_n)
		remaining_q <= CNT_W'(MAX_COUNT))
		else $error("remaining count above table depth");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_wa) < remaining_q))
		else $error("table write outside live entries");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside completion");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV))
		else $error("modulo finished outside its wait");

	a_final_is_draw: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && final_draw_q) |-> (status_q == STAT_DRAWN))
		else $error("final flag on a non-draw result");
`endif

endmodule
